>>> design/pdac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdac_pkg;

    localparam int YEAR_BITS_DEF = 14;

    localparam int ACTION_BITS = 2;
    localparam int MONTH_BITS  = 4;
    localparam int IN_DAY_BITS = 5;
    localparam int DAY_BITS    = 6;
    localparam int HOUR_BITS   = 5;
    localparam int MINUTE_BITS = 6;
    localparam int DEPTH_BITS  = 3;

    localparam logic [ACTION_BITS-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_ADD     = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_COMPARE = 2'd2;

    // depth codes: number of present levels below the year
    localparam logic [DEPTH_BITS-1:0] LVL_MONTH  = 3'd1;
    localparam logic [DEPTH_BITS-1:0] LVL_DAY    = 3'd2;
    localparam logic [DEPTH_BITS-1:0] LVL_HOUR   = 3'd3;
    localparam logic [DEPTH_BITS-1:0] LVL_MINUTE = 3'd4;

    localparam logic [MONTH_BITS-1:0]  MONTH_MAX   = 4'd11;
    localparam logic [IN_DAY_BITS-1:0] IN_DAY_MAX  = 5'd30;
    localparam logic [HOUR_BITS-1:0]   HOUR_MAX    = 5'd23;
    localparam logic [MINUTE_BITS-1:0] MINUTE_MAX  = 6'd59;
    localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX   = 3'd4;
    localparam logic [DAY_BITS-1:0]    DAY_MAX     = 6'd63;

    localparam int MINUTES_PER_HOUR = 60;
    localparam int HOURS_PER_DAY    = 24;
    localparam int MONTHS_PER_YEAR  = 12;

    // floor(y / 25) == (y * DIV25_MULT) >> DIV25_SHIFT, exact for y below 2^16
    localparam int          DIV25_SHIFT = 21;
    localparam logic [16:0] DIV25_MULT  = 17'd83887;

    typedef struct packed {
        logic [MONTH_BITS-1:0]  month;
        logic [DAY_BITS-1:0]    day;
        logic [HOUR_BITS-1:0]   hour;
        logic [MINUTE_BITS-1:0] minute;
        logic [DEPTH_BITS-1:0]  depth;
    } date_lo_t;

    typedef struct packed {
        logic less;
        logic greater;
        logic equal;
    } cmp_flags_t;

    function automatic logic [4:0] month_len(input logic [MONTH_BITS-1:0] month,
                                             input logic leap);
        logic [4:0] len;
        case (month)
            4'd1: begin
                len = leap ? 5'd29 : 5'd28;
            end
            4'd3, 4'd5, 4'd8, 4'd10: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

>>> design/partial_date_add_compare_top.sv
// A request loads the input register on acceptance; the held date and result register
// load from it once the result register is empty or its result is being taken.
// Throughput: one request per cycle while the receiver takes results; the add
// carry chain, the leap-year test and the field compare all settle within the second stage.
// Reset (aresetn low, synchronous): both stages empty, held date cleared to
// no year and no levels.
`timescale 1ns / 1ps
`default_nettype none

module partial_date_add_compare_top #(
    parameter int YEAR_BITS = pdac_pkg::YEAR_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [pdac_pkg::ACTION_BITS-1:0]   s_action,
    input  wire logic [YEAR_BITS-1:0]               s_in_year,
    input  wire logic                               s_in_year_valid,
    input  wire logic [pdac_pkg::MONTH_BITS-1:0]    s_in_month,
    input  wire logic [pdac_pkg::IN_DAY_BITS-1:0]   s_in_day,
    input  wire logic [pdac_pkg::HOUR_BITS-1:0]     s_in_hour,
    input  wire logic [pdac_pkg::MINUTE_BITS-1:0]   s_in_minute,
    input  wire logic [pdac_pkg::DEPTH_BITS-1:0]    s_in_depth,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [YEAR_BITS-1:0]                    m_out_year,
    output logic                                    m_out_year_valid,
    output logic [pdac_pkg::MONTH_BITS-1:0]         m_out_month,
    output logic [pdac_pkg::DAY_BITS-1:0]           m_out_day,
    output logic [pdac_pkg::HOUR_BITS-1:0]          m_out_hour,
    output logic [pdac_pkg::MINUTE_BITS-1:0]        m_out_minute,
    output logic [pdac_pkg::DEPTH_BITS-1:0]         m_out_depth,
    output logic                                    m_is_less,
    output logic                                    m_is_greater,
    output logic                                    m_is_equal
);

    logic                               s1_valid_reg;
    logic [pdac_pkg::ACTION_BITS-1:0]   s1_action_reg;
    logic [YEAR_BITS-1:0]               s1_year_reg;
    logic                               s1_yv_reg;
    pdac_pkg::date_lo_t                 s1_lo_reg;

    logic                               m_valid_reg;
    logic [YEAR_BITS-1:0]               held_year_reg;
    logic                               held_yv_reg;
    pdac_pkg::date_lo_t                 held_lo_reg;
    pdac_pkg::cmp_flags_t               flags_reg;

    logic [YEAR_BITS-1:0]               held_year_next;
    logic                               held_yv_next;
    pdac_pkg::date_lo_t                 held_lo_next;
    pdac_pkg::cmp_flags_t               flags_next;

    logic [pdac_pkg::DEPTH_BITS-1:0]    in_depth_sat;
    pdac_pkg::date_lo_t                 in_lo;
    logic                               s_fire;
    logic                               s1_fire;

    assign s1_fire = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_fire;
    assign s_fire  = s_valid && s_ready;

    // saturate each field, then drop the levels below the depth
    always_comb begin
        in_depth_sat = (s_in_depth > pdac_pkg::DEPTH_MAX) ? pdac_pkg::DEPTH_MAX : s_in_depth;
        in_lo.depth  = in_depth_sat;
        in_lo.month  = '0;
        in_lo.day    = '0;
        in_lo.hour   = '0;
        in_lo.minute = '0;
        if (in_depth_sat >= pdac_pkg::LVL_MONTH) begin
            in_lo.month = (s_in_month > pdac_pkg::MONTH_MAX) ? pdac_pkg::MONTH_MAX : s_in_month;
        end
        if (in_depth_sat >= pdac_pkg::LVL_DAY) begin
            in_lo.day = pdac_pkg::DAY_BITS'((s_in_day > pdac_pkg::IN_DAY_MAX)
                                            ? pdac_pkg::IN_DAY_MAX : s_in_day);
        end
        if (in_depth_sat >= pdac_pkg::LVL_HOUR) begin
            in_lo.hour = (s_in_hour > pdac_pkg::HOUR_MAX) ? pdac_pkg::HOUR_MAX : s_in_hour;
        end
        if (in_depth_sat >= pdac_pkg::LVL_MINUTE) begin
            in_lo.minute = (s_in_minute > pdac_pkg::MINUTE_MAX)
                           ? pdac_pkg::MINUTE_MAX : s_in_minute;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_action_reg <= s_action;
            s1_year_reg   <= s_in_year_valid ? s_in_year : '0;
            s1_yv_reg     <= s_in_year_valid;
            s1_lo_reg     <= in_lo;
        end
    end

    pdac_step #(
        .YEAR_BITS (YEAR_BITS)
    ) u_step (
        .action    (s1_action_reg),
        .held_year (held_year_reg),
        .held_yv   (held_yv_reg),
        .held_lo   (held_lo_reg),
        .in_year   (s1_year_reg),
        .in_yv     (s1_yv_reg),
        .in_lo     (s1_lo_reg),
        .next_year (held_year_next),
        .next_yv   (held_yv_next),
        .next_lo   (held_lo_next),
        .flags     (flags_next)
    );

    // held date doubles as the result payload: it only advances once the result is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            held_year_reg <= '0;
            held_yv_reg   <= 1'b0;
            held_lo_reg   <= '0;
        end else if (s1_fire) begin
            m_valid_reg   <= 1'b1;
            held_year_reg <= held_year_next;
            held_yv_reg   <= held_yv_next;
            held_lo_reg   <= held_lo_next;
        end else if (m_ready) begin
            m_valid_reg   <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            flags_reg <= flags_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_year       = held_year_reg;
    assign m_out_year_valid = held_yv_reg;
    assign m_out_month      = held_lo_reg.month;
    assign m_out_day        = held_lo_reg.day;
    assign m_out_hour       = held_lo_reg.hour;
    assign m_out_minute     = held_lo_reg.minute;
    assign m_out_depth      = held_lo_reg.depth;
    assign m_is_less        = flags_reg.less;
    assign m_is_greater     = flags_reg.greater;
    assign m_is_equal       = flags_reg.equal;

endmodule

`default_nettype wire

>>> design/pdac_step.sv
`timescale 1ns / 1ps
`default_nettype none

module pdac_step #(
    parameter int YEAR_BITS = pdac_pkg::YEAR_BITS_DEF
) (
    input  wire logic [pdac_pkg::ACTION_BITS-1:0] action,
    input  wire logic [YEAR_BITS-1:0]             held_year,
    input  wire logic                             held_yv,
    input  wire pdac_pkg::date_lo_t               held_lo,
    input  wire logic [YEAR_BITS-1:0]             in_year,
    input  wire logic                             in_yv,
    input  wire pdac_pkg::date_lo_t               in_lo,
    output logic [YEAR_BITS-1:0]                  next_year,
    output logic                                  next_yv,
    output pdac_pkg::date_lo_t                    next_lo,
    output pdac_pkg::cmp_flags_t                  flags
);

    localparam int PROD_BITS = YEAR_BITS + $bits(pdac_pkg::DIV25_MULT);
    localparam int Q_BITS    = PROD_BITS - pdac_pkg::DIV25_SHIFT;

    logic [PROD_BITS-1:0]                 prod;
    logic [Q_BITS-1:0]                    quot;
    logic [YEAR_BITS:0]                   quot_x;
    logic [YEAR_BITS:0]                   quot25;
    logic                                 div25;
    logic                                 leap;
    logic [4:0]                           len;
    logic [pdac_pkg::DEPTH_BITS-1:0]      lvl;
    logic                                 yv_both;

    logic [pdac_pkg::MINUTE_BITS:0]       min_sum;
    logic                                 min_c;
    logic [pdac_pkg::HOUR_BITS:0]         hour_sum;
    logic                                 hour_c;
    logic [pdac_pkg::DAY_BITS:0]          day_sum;
    logic                                 day_c;
    logic [pdac_pkg::DAY_BITS:0]          day_red;
    logic [pdac_pkg::MONTH_BITS:0]        month_sum;
    logic                                 month_c;
    logic [YEAR_BITS:0]                   year_sum;

    logic [YEAR_BITS-1:0]                 add_year;
    pdac_pkg::date_lo_t                   add_lo;
    logic                                 lt;
    logic                                 gt;

    // Gregorian leap test on the held year: divisible by 4, and not by 100 unless by 400
    assign prod   = PROD_BITS'(held_year) * PROD_BITS'(pdac_pkg::DIV25_MULT);
    assign quot   = prod[PROD_BITS-1:pdac_pkg::DIV25_SHIFT];
    assign quot_x = (YEAR_BITS+1)'(quot);
    assign quot25 = (quot_x << 4) + (quot_x << 3) + quot_x;
    assign div25  = (quot25 == {1'b0, held_year});
    assign leap   = held_yv && (held_year[1:0] == 2'b00)
                    && (!div25 || (held_year[3:0] == 4'b0000));
    assign len    = pdac_pkg::month_len(held_lo.month, leap);

    assign lvl     = (held_lo.depth < in_lo.depth) ? held_lo.depth : in_lo.depth;
    assign yv_both = held_yv && in_yv;

    always_comb begin
        min_sum  = (pdac_pkg::MINUTE_BITS+1)'(held_lo.minute)
                 + (pdac_pkg::MINUTE_BITS+1)'(in_lo.minute);
        min_c    = (lvl >= pdac_pkg::LVL_MINUTE) && (min_sum >= pdac_pkg::MINUTES_PER_HOUR);

        hour_sum = (pdac_pkg::HOUR_BITS+1)'(held_lo.hour)
                 + (pdac_pkg::HOUR_BITS+1)'(in_lo.hour)
                 + (pdac_pkg::HOUR_BITS+1)'(min_c);
        hour_c   = (lvl >= pdac_pkg::LVL_HOUR) && (hour_sum >= pdac_pkg::HOURS_PER_DAY);

        // one subtraction of the held month's length only
        day_sum  = (pdac_pkg::DAY_BITS+1)'(held_lo.day)
                 + (pdac_pkg::DAY_BITS+1)'(in_lo.day)
                 + (pdac_pkg::DAY_BITS+1)'(hour_c);
        day_c    = (lvl >= pdac_pkg::LVL_DAY) && (day_sum >= (pdac_pkg::DAY_BITS+1)'(len));
        day_red  = day_c ? day_sum - (pdac_pkg::DAY_BITS+1)'(len) : day_sum;

        month_sum = (pdac_pkg::MONTH_BITS+1)'(held_lo.month)
                  + (pdac_pkg::MONTH_BITS+1)'(in_lo.month)
                  + (pdac_pkg::MONTH_BITS+1)'(day_c);
        month_c   = (lvl >= pdac_pkg::LVL_MONTH) && (month_sum >= pdac_pkg::MONTHS_PER_YEAR);

        year_sum = {1'b0, held_year} + {1'b0, in_year} + (YEAR_BITS+1)'(month_c);

        add_year = '0;
        if (yv_both) begin
            add_year = year_sum[YEAR_BITS] ? '1 : year_sum[YEAR_BITS-1:0];
        end

        add_lo.depth  = lvl;
        add_lo.minute = '0;
        add_lo.hour   = '0;
        add_lo.day    = '0;
        add_lo.month  = '0;
        if (lvl >= pdac_pkg::LVL_MINUTE) begin
            add_lo.minute = min_c ? pdac_pkg::MINUTE_BITS'(min_sum - pdac_pkg::MINUTES_PER_HOUR)
                                  : min_sum[pdac_pkg::MINUTE_BITS-1:0];
        end
        if (lvl >= pdac_pkg::LVL_HOUR) begin
            add_lo.hour = hour_c ? pdac_pkg::HOUR_BITS'(hour_sum - pdac_pkg::HOURS_PER_DAY)
                                 : hour_sum[pdac_pkg::HOUR_BITS-1:0];
        end
        if (lvl >= pdac_pkg::LVL_DAY) begin
            add_lo.day = day_red[pdac_pkg::DAY_BITS] ? pdac_pkg::DAY_MAX
                                                     : day_red[pdac_pkg::DAY_BITS-1:0];
        end
        if (lvl >= pdac_pkg::LVL_MONTH) begin
            add_lo.month = month_c
                ? pdac_pkg::MONTH_BITS'(month_sum - pdac_pkg::MONTHS_PER_YEAR)
                : month_sum[pdac_pkg::MONTH_BITS-1:0];
        end
    end

    // first differing present field decides; an absent level ends the test as equal
    always_comb begin
        lt = 1'b0;
        gt = 1'b0;
        if (yv_both && (held_year != in_year)) begin
            lt = held_year < in_year;
            gt = held_year > in_year;
        end else if (lvl < pdac_pkg::LVL_MONTH) begin
            lt = 1'b0;
        end else if (held_lo.month != in_lo.month) begin
            lt = held_lo.month < in_lo.month;
            gt = held_lo.month > in_lo.month;
        end else if (lvl < pdac_pkg::LVL_DAY) begin
            lt = 1'b0;
        end else if (held_lo.day != in_lo.day) begin
            lt = held_lo.day < in_lo.day;
            gt = held_lo.day > in_lo.day;
        end else if (lvl < pdac_pkg::LVL_HOUR) begin
            lt = 1'b0;
        end else if (held_lo.hour != in_lo.hour) begin
            lt = held_lo.hour < in_lo.hour;
            gt = held_lo.hour > in_lo.hour;
        end else if (lvl >= pdac_pkg::LVL_MINUTE) begin
            lt = held_lo.minute < in_lo.minute;
            gt = held_lo.minute > in_lo.minute;
        end
    end

    always_comb begin
        next_year = held_year;
        next_yv   = held_yv;
        next_lo   = held_lo;
        flags     = '0;
        case (action)
            pdac_pkg::ACT_LOAD: begin
                next_year = in_year;
                next_yv   = in_yv;
                next_lo   = in_lo;
            end
            pdac_pkg::ACT_ADD: begin
                next_year = add_year;
                next_yv   = yv_both;
                next_lo   = add_lo;
            end
            pdac_pkg::ACT_COMPARE: begin
                flags.less    = lt;
                flags.greater = gt;
                flags.equal   = !lt && !gt;
            end
            default: begin
                flags = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/pdac_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pdac_checker #(
    parameter int YEAR_BITS = pdac_pkg::YEAR_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               m_valid,
    input  wire logic                               m_ready,
    input  wire logic [YEAR_BITS-1:0]               m_out_year,
    input  wire logic                               m_out_year_valid,
    input  wire logic [pdac_pkg::DAY_BITS-1:0]      m_out_day,
    input  wire logic [pdac_pkg::HOUR_BITS-1:0]     m_out_hour,
    input  wire logic [pdac_pkg::MINUTE_BITS-1:0]   m_out_minute,
    input  wire logic [pdac_pkg::DEPTH_BITS-1:0]    m_out_depth,
    input  wire logic                               m_is_less,
    input  wire logic                               m_is_greater,
    input  wire logic                               m_is_equal
);

    // at most one compare flag per result
    a_flags_onehot0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_is_less, m_is_greater, m_is_equal}))
        else $error("more than one compare flag set");

    a_depth_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_depth <= pdac_pkg::DEPTH_MAX))
        else $error("result depth out of range");

    a_absent_year_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_out_year_valid) |-> (m_out_year == '0))
        else $error("absent year not zero");

    a_absent_levels_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_out_depth >= pdac_pkg::LVL_DAY || m_out_day == '0)
                  && (m_out_depth >= pdac_pkg::LVL_HOUR || m_out_hour == '0)
                  && (m_out_depth >= pdac_pkg::LVL_MINUTE || m_out_minute == '0)))
        else $error("absent level not zero");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_year) && $stable(m_out_day)))
        else $error("stalled result changed");

endmodule

bind partial_date_add_compare_top pdac_checker #(
    .YEAR_BITS (YEAR_BITS)
) u_pdac_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_out_year       (m_out_year),
    .m_out_year_valid (m_out_year_valid),
    .m_out_day        (m_out_day),
    .m_out_hour       (m_out_hour),
    .m_out_minute     (m_out_minute),
    .m_out_depth      (m_out_depth),
    .m_is_less        (m_is_less),
    .m_is_greater     (m_is_greater),
    .m_is_equal       (m_is_equal)
);

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pdac_pkg::*;

    localparam int YEAR_BITS    = YEAR_BITS_DEF;
    localparam int YEAR_TOP     = (1 << YEAR_BITS) - 1;
    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 10;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 550;
    localparam int MAX_PRINTED  = 20;
    localparam int GROWTH_ADDS  = 17;

    localparam logic [ACTION_BITS-1:0] ACT_NOP  = 2'd3;
    localparam logic [DEPTH_BITS-1:0]  LVL_NONE = 3'd0;
    localparam logic [DEPTH_BITS-1:0]  LVL_OVER = 3'd7;
    localparam logic [MONTH_BITS-1:0]  FEB      = 4'd1;

    typedef struct {
        logic [ACTION_BITS-1:0] action;
        logic [YEAR_BITS-1:0]   year;
        logic                   yv;
        logic [MONTH_BITS-1:0]  month;
        logic [IN_DAY_BITS-1:0] day;
        logic [HOUR_BITS-1:0]   hour;
        logic [MINUTE_BITS-1:0] minute;
        logic [DEPTH_BITS-1:0]  depth;
    } request_t;

    typedef struct {
        logic [YEAR_BITS-1:0]   year;
        logic                   yv;
        logic [MONTH_BITS-1:0]  month;
        logic [DAY_BITS-1:0]    day;
        logic [HOUR_BITS-1:0]   hour;
        logic [MINUTE_BITS-1:0] minute;
        logic [DEPTH_BITS-1:0]  depth;
    } cal_date_t;

    typedef struct {
        cal_date_t d;
        logic      less;
        logic      greater;
        logic      equal;
    } date_result_t;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [ACTION_BITS-1:0] s_action = ACT_LOAD;
    logic [YEAR_BITS-1:0]   s_in_year = '0;
    logic                   s_in_year_valid = 1'b0;
    logic [MONTH_BITS-1:0]  s_in_month = '0;
    logic [IN_DAY_BITS-1:0] s_in_day = '0;
    logic [HOUR_BITS-1:0]   s_in_hour = '0;
    logic [MINUTE_BITS-1:0] s_in_minute = '0;
    logic [DEPTH_BITS-1:0]  s_in_depth = LVL_NONE;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [YEAR_BITS-1:0]   m_out_year;
    logic                   m_out_year_valid;
    logic [MONTH_BITS-1:0]  m_out_month;
    logic [DAY_BITS-1:0]    m_out_day;
    logic [HOUR_BITS-1:0]   m_out_hour;
    logic [MINUTE_BITS-1:0] m_out_minute;
    logic [DEPTH_BITS-1:0]  m_out_depth;
    logic                   m_is_less;
    logic                   m_is_greater;
    logic                   m_is_equal;

    cal_date_t    held_now;
    date_result_t expected_dates[$];

    int errors = 0;
    int n_sent = 0;
    int n_results = 0;
    int n_load = 0, n_add = 0, n_cmp = 0, n_nop = 0;
    int n_less = 0, n_greater = 0, n_equal = 0;
    int day_clips = 0, year_clips = 0;
    int quiet_cycles = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;

    logic [15:0] stall_mask = '1;
    logic [3:0]  stall_pos = '0;
    int          stall_age = 0;

    partial_date_add_compare_top #(
        .YEAR_BITS(YEAR_BITS)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_in_year       (s_in_year),
        .s_in_year_valid (s_in_year_valid),
        .s_in_month      (s_in_month),
        .s_in_day        (s_in_day),
        .s_in_hour       (s_in_hour),
        .s_in_minute     (s_in_minute),
        .s_in_depth      (s_in_depth),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_year      (m_out_year),
        .m_out_year_valid(m_out_year_valid),
        .m_out_month     (m_out_month),
        .m_out_day       (m_out_day),
        .m_out_hour      (m_out_hour),
        .m_out_minute    (m_out_minute),
        .m_out_depth     (m_out_depth),
        .m_is_less       (m_is_less),
        .m_is_greater    (m_is_greater),
        .m_is_equal      (m_is_equal)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // ---------------------------------------------------------------- prediction

    function automatic bit is_leap(input int y);
        if (y % 100 == 0) begin
            return ((y / 100) % 4) == 0;
        end
        return (y % 4) == 0;
    endfunction

    function automatic int days_in_month(input logic [MONTH_BITS-1:0] m, input bit leap);
        int lens [12];
        lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == FEB && leap) begin
            return 29;
        end
        return lens[(m > MONTH_MAX) ? MONTH_MAX : m];
    endfunction

    function automatic cal_date_t clear_absent(input cal_date_t d);
        if (!d.yv) d.year = '0;
        if (d.depth < LVL_MONTH) d.month = '0;
        if (d.depth < LVL_DAY) d.day = '0;
        if (d.depth < LVL_HOUR) d.hour = '0;
        if (d.depth < LVL_MINUTE) d.minute = '0;
        return d;
    endfunction

    function automatic cal_date_t from_request(input request_t r);
        cal_date_t d;
        d.year   = r.year;
        d.yv     = r.yv;
        d.month  = (r.month > MONTH_MAX) ? MONTH_MAX : r.month;
        d.day    = r.day;
        if (d.day > IN_DAY_MAX) d.day = IN_DAY_MAX;
        d.hour   = (r.hour > HOUR_MAX) ? HOUR_MAX : r.hour;
        d.minute = (r.minute > MINUTE_MAX) ? MINUTE_MAX : r.minute;
        d.depth  = (r.depth > DEPTH_MAX) ? DEPTH_MAX : r.depth;
        return clear_absent(d);
    endfunction

    function automatic cal_date_t add_dates(input cal_date_t a, input cal_date_t b);
        cal_date_t sum;
        int lvl, mlen, yr, mo, dy, hr, mi;
        bit yv;
        mlen = days_in_month(a.month, a.yv && is_leap(a.year));
        lvl  = (a.depth < b.depth) ? a.depth : b.depth;
        yv   = a.yv & b.yv;
        yr   = a.year;
        mo   = a.month;
        dy   = a.day;
        hr   = a.hour;
        mi   = a.minute;
        // one carry per level, low to high
        if (lvl >= LVL_MINUTE) begin
            mi += b.minute;
            if (mi >= MINUTES_PER_HOUR) begin
                mi -= MINUTES_PER_HOUR;
                hr++;
            end
        end
        if (lvl >= LVL_HOUR) begin
            hr += b.hour;
            if (hr >= HOURS_PER_DAY) begin
                hr -= HOURS_PER_DAY;
                dy++;
            end
        end
        if (lvl >= LVL_DAY) begin
            dy += b.day;
            if (dy >= mlen) begin
                dy -= mlen;
                mo++;
            end
            if (dy > DAY_MAX) begin
                dy = DAY_MAX;
                day_clips++;
            end
        end
        if (lvl >= LVL_MONTH) begin
            mo += b.month;
            if (mo >= MONTHS_PER_YEAR) begin
                mo -= MONTHS_PER_YEAR;
                yr++;
            end
        end
        if (yv) begin
            yr += b.year;
            if (yr > YEAR_TOP) begin
                yr = YEAR_TOP;
                year_clips++;
            end
        end
        sum.year   = yr;
        sum.yv     = yv;
        sum.month  = mo;
        sum.day    = dy;
        sum.hour   = hr;
        sum.minute = mi;
        sum.depth  = lvl;
        return clear_absent(sum);
    endfunction

    // -1 held first, 1 held later, 0 equal at the shared precision
    function automatic int order_dates(input cal_date_t a, input cal_date_t b);
        if (a.yv && b.yv && a.year != b.year) return (a.year < b.year) ? -1 : 1;
        if (a.depth < LVL_MONTH || b.depth < LVL_MONTH) return 0;
        if (a.month != b.month) return (a.month < b.month) ? -1 : 1;
        if (a.depth < LVL_DAY || b.depth < LVL_DAY) return 0;
        if (a.day != b.day) return (a.day < b.day) ? -1 : 1;
        if (a.depth < LVL_HOUR || b.depth < LVL_HOUR) return 0;
        if (a.hour != b.hour) return (a.hour < b.hour) ? -1 : 1;
        if (a.depth < LVL_MINUTE || b.depth < LVL_MINUTE) return 0;
        if (a.minute != b.minute) return (a.minute < b.minute) ? -1 : 1;
        return 0;
    endfunction

    function automatic date_result_t step_held_date(input request_t r);
        date_result_t res;
        cal_date_t    in_d;
        int           ord;
        in_d        = from_request(r);
        res.less    = 1'b0;
        res.greater = 1'b0;
        res.equal   = 1'b0;
        case (r.action)
            ACT_LOAD: begin
                held_now = in_d;
                n_load++;
            end
            ACT_ADD: begin
                held_now = add_dates(held_now, in_d);
                n_add++;
            end
            ACT_COMPARE: begin
                ord         = order_dates(held_now, in_d);
                res.less    = ord < 0;
                res.greater = ord > 0;
                res.equal   = ord == 0;
                n_cmp++;
                if (ord < 0) n_less++;
                else if (ord > 0) n_greater++;
                else n_equal++;
            end
            default: begin
                n_nop++;
            end
        endcase
        res.d = held_now;
        return res;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_PRINTED) begin
            $display("tb_top: result %0d: %s is %0d, expected %0d", n_results, what, got, want);
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        request_t     req;
        date_result_t want;
        if (aresetn) begin
            // retire the older result before queuing a new request
            if (m_valid && m_ready) begin
                if (expected_dates.size() == 0) begin
                    report_mismatch("result with nothing pending, valid", 1, 0);
                end else begin
                    want = expected_dates.pop_front();
                    if (m_out_year !== want.d.year)
                        report_mismatch("year", m_out_year, want.d.year);
                    if (m_out_year_valid !== want.d.yv)
                        report_mismatch("year_valid", m_out_year_valid, want.d.yv);
                    if (m_out_month !== want.d.month)
                        report_mismatch("month", m_out_month, want.d.month);
                    if (m_out_day !== want.d.day)
                        report_mismatch("day", m_out_day, want.d.day);
                    if (m_out_hour !== want.d.hour)
                        report_mismatch("hour", m_out_hour, want.d.hour);
                    if (m_out_minute !== want.d.minute)
                        report_mismatch("minute", m_out_minute, want.d.minute);
                    if (m_out_depth !== want.d.depth)
                        report_mismatch("depth", m_out_depth, want.d.depth);
                    if (m_is_less !== want.less)
                        report_mismatch("is_less", m_is_less, want.less);
                    if (m_is_greater !== want.greater)
                        report_mismatch("is_greater", m_is_greater, want.greater);
                    if (m_is_equal !== want.equal)
                        report_mismatch("is_equal", m_is_equal, want.equal);
                end
                n_results++;
            end
            if (s_valid && s_ready) begin
                req.action = s_action;
                req.year   = s_in_year;
                req.yv     = s_in_year_valid;
                req.month  = s_in_month;
                req.day    = s_in_day;
                req.hour   = s_in_hour;
                req.minute = s_in_minute;
                req.depth  = s_in_depth;
                expected_dates.push_back(step_held_date(req));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_top: no handshake for %0d cycles", IDLE_LIMIT);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // receiver: rotate a stall mask, picking a fresh one when its age runs out
    always @(negedge aclk) begin
        if (stall_age == 0) begin
            stall_age = 64;
            if ($urandom_range(0, 3) == 0) stall_mask = '1;
            else stall_mask = $urandom | 16'h0001;
        end
        stall_age--;
        m_ready = stall_mask[stall_pos];
        stall_pos++;
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_request(input request_t r);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            repeat (gap) begin
                @(negedge aclk);
                s_valid = 1'b0;
                @(posedge aclk);
            end
        end
        if (burst_left > 0) burst_left--;
        @(negedge aclk);
        s_valid         = 1'b1;
        s_action        = r.action;
        s_in_year       = r.year;
        s_in_year_valid = r.yv;
        s_in_month      = r.month;
        s_in_day        = r.day;
        s_in_hour       = r.hour;
        s_in_minute     = r.minute;
        s_in_depth      = r.depth;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    task automatic send_date(input logic [ACTION_BITS-1:0] act, input int year, input logic yv,
                             input int month, input int day, input int hour, input int minute,
                             input logic [DEPTH_BITS-1:0] depth);
        request_t r;
        r.action = act;
        r.year   = year;
        r.yv     = yv;
        r.month  = month;
        r.day    = day;
        r.hour   = hour;
        r.minute = minute;
        r.depth  = depth;
        send_request(r);
    endtask

    function automatic int pick_year();
        int notable [11];
        notable = '{0, 4, 100, 400, 1900, 2000, 2023, 2024, 2100, YEAR_TOP - 383, YEAR_TOP};
        case ($urandom_range(0, 5))
            0: return notable[$urandom_range(0, 10)];
            1, 2: return $urandom_range(0, 3000);
            default: return $urandom_range(0, YEAR_TOP);
        endcase
    endfunction

    function automatic request_t rand_date(input logic [ACTION_BITS-1:0] act);
        request_t r;
        r.action = act;
        r.year   = pick_year();
        r.yv     = $urandom_range(0, 5) != 0;
        r.month  = $urandom_range(0, MONTH_MAX);
        r.day    = $urandom_range(0, IN_DAY_MAX);
        r.hour   = $urandom_range(0, HOUR_MAX);
        r.minute = $urandom_range(0, MINUTE_MAX);
        r.depth  = ($urandom_range(0, 2) != 0) ? DEPTH_MAX : $urandom_range(0, DEPTH_MAX);
        return r;
    endfunction

    function automatic int bump(input int v, input int hi);
        if ($urandom_range(0, 1) && v < hi) return v + 1;
        if (v > 0) return v - 1;
        return v + 1;
    endfunction

    // compare against the held date with at most one field nudged
    function automatic request_t near_held();
        request_t r;
        r        = rand_date(ACT_COMPARE);
        r.year   = held_now.year;
        r.yv     = held_now.yv | ($urandom_range(0, 3) == 0);
        r.month  = held_now.month;
        r.day    = (held_now.day > IN_DAY_MAX) ? IN_DAY_MAX : held_now.day;
        r.hour   = held_now.hour;
        r.minute = held_now.minute;
        if ($urandom_range(0, 1)) r.depth = held_now.depth;
        case ($urandom_range(0, 5))
            0: r.year = bump(r.year, YEAR_TOP);
            1: r.month = bump(r.month, MONTH_MAX);
            2: r.day = bump(r.day, IN_DAY_MAX);
            3: r.hour = bump(r.hour, HOUR_MAX);
            4: r.minute = bump(r.minute, MINUTE_MAX);
            default: ;
        endcase
        return r;
    endfunction

    function automatic request_t noise_request();
        request_t r;
        r.action = $urandom;
        r.year   = $urandom;
        r.yv     = $urandom;
        r.month  = $urandom;
        r.day    = $urandom;
        r.hour   = $urandom;
        r.minute = $urandom;
        r.depth  = $urandom;
        return r;
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_load_extremes();
        send_date(ACT_LOAD, YEAR_TOP, 1'b1, MONTH_MAX, IN_DAY_MAX, HOUR_MAX, MINUTE_MAX,
                  LVL_MINUTE);
        // absent year and levels must read back as zero
        send_date(ACT_LOAD, 5, 1'b0, 7, 12, 9, 33, LVL_NONE);
        // out-of-range fields saturate
        send_date(ACT_LOAD, 0, 1'b1, 15, 31, 31, 63, LVL_OVER);
    endtask

    task automatic test_add_carries();
        // leap February: minute carry ripples through to March 1st
        send_date(ACT_LOAD, 2024, 1'b1, FEB, 28, HOUR_MAX, MINUTE_MAX, LVL_MINUTE);
        send_date(ACT_ADD, 0, 1'b1, 0, 0, 0, 1, LVL_MINUTE);
        // century non-leap February has 28 days
        send_date(ACT_LOAD, 1900, 1'b1, FEB, 27, 0, 0, LVL_DAY);
        send_date(ACT_ADD, 0, 1'b1, 0, 1, 0, 0, LVL_DAY);
        // every carry plus year saturation
        send_date(ACT_LOAD, YEAR_TOP, 1'b1, MONTH_MAX, IN_DAY_MAX, HOUR_MAX, MINUTE_MAX,
                  LVL_MINUTE);
        send_date(ACT_ADD, YEAR_TOP, 1'b1, MONTH_MAX, IN_DAY_MAX, HOUR_MAX, MINUTE_MAX,
                  LVL_MINUTE);
        // absent input year drops the held year; shallower depth wins
        send_date(ACT_ADD, 3, 1'b0, 4, 5, 6, 7, LVL_MONTH);
        // day left past the month length after one subtraction
        send_date(ACT_LOAD, 0, 1'b0, FEB, IN_DAY_MAX, 0, 0, LVL_DAY);
        send_date(ACT_ADD, 0, 1'b0, MONTH_MAX, IN_DAY_MAX, 0, 0, LVL_DAY);
        send_date(ACT_ADD, 0, 1'b0, 0, IN_DAY_MAX, 0, 0, LVL_DAY);
    endtask

    task automatic test_compare_levels();
        send_date(ACT_LOAD, 2000, 1'b1, 5, 10, 12, 30, LVL_MINUTE);
        send_date(ACT_COMPARE, 2000, 1'b1, 5, 10, 12, 30, LVL_MINUTE);
        send_date(ACT_COMPARE, 1999, 1'b1, 5, 10, 12, 30, LVL_MINUTE);
        // missing year takes the other one
        send_date(ACT_COMPARE, 1999, 1'b0, 5, 10, 12, 31, LVL_MINUTE);
        // hour level absent in the input ends the test as equal
        send_date(ACT_COMPARE, 2000, 1'b1, 5, 10, 3, 0, LVL_DAY);
        send_date(ACT_COMPARE, 2000, 1'b1, 6, 10, 12, 30, LVL_MINUTE);
        send_date(ACT_COMPARE, 2000, 1'b1, 5, 10, 11, 30, LVL_MINUTE);
        send_date(ACT_COMPARE, 2000, 1'b1, 0, 0, 0, 0, LVL_NONE);
    endtask

    task automatic test_unknown_action();
        send_date(ACT_NOP, YEAR_TOP, 1'b1, 15, 31, 31, 63, LVL_OVER);
    endtask

    task automatic test_random_traffic();
        request_t r;
        int       target, kind, steps;
        target = n_sent + RANDOM_ITEMS;
        while (n_sent < target) begin
            if ($urandom_range(0, 7) == 0) gaps_on = !gaps_on;
            kind = $urandom_range(0, 19);
            if (kind < 8) begin
                send_request(rand_date(ACT_LOAD));
                steps = $urandom_range(2, 8);
                repeat (steps) begin
                    if ($urandom_range(0, 1)) begin
                        r = rand_date(ACT_ADD);
                        if ($urandom_range(0, 3) != 0) r.year = $urandom_range(0, 3);
                        send_request(r);
                    end else begin
                        send_request(near_held());
                    end
                end
            end else if (kind < 10) begin
                // non-leap February, day grows by two per add and clips if it passes the top
                send_date(ACT_LOAD, pick_year(), 1'b0, FEB, $urandom_range(20, IN_DAY_MAX),
                          0, 0, LVL_DAY);
                repeat (GROWTH_ADDS) begin
                    send_date(ACT_ADD, pick_year(), $urandom_range(0, 1), MONTH_MAX,
                              IN_DAY_MAX, 0, 0, LVL_DAY);
                end
                send_request(near_held());
            end else if (kind < 13) begin
                r       = rand_date(ACT_LOAD);
                r.month = FEB;
                r.day   = $urandom_range(25, 28);
                r.hour  = HOUR_MAX;
                r.minute = MINUTE_MAX;
                r.yv    = 1'b1;
                r.depth = $urandom_range(LVL_DAY, LVL_MINUTE);
                send_request(r);
                send_date(ACT_ADD, 0, $urandom_range(0, 1), 0, $urandom_range(0, 2),
                          $urandom_range(0, 1), $urandom_range(0, 1), LVL_MINUTE);
                send_request(near_held());
            end else if (kind < 16) begin
                steps = $urandom_range(1, 6);
                repeat (steps) send_request(noise_request());
            end else begin
                send_date(ACT_LOAD, YEAR_TOP - $urandom_range(0, 2), 1'b1, MONTH_MAX,
                          IN_DAY_MAX, HOUR_MAX, MINUTE_MAX, LVL_MINUTE);
                r = rand_date(ACT_ADD);
                r.yv = 1'b1;
                send_request(r);
                send_request(near_held());
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_load_extremes();
        test_add_carries();
        test_compare_levels();
        test_unknown_action();
        test_random_traffic();

        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_dates.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb_top: %0d requests (%0d load, %0d add, %0d compare, %0d unknown), %0d results",
                 n_sent, n_load, n_add, n_cmp, n_nop, n_results);
        $display("tb_top: compares less/greater/equal %0d/%0d/%0d, day clips %0d, year clips %0d",
                 n_less, n_greater, n_equal, day_clips, year_clips);
        if (errors == 0 && expected_dates.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
